// ----- hw/rtl/rlsfd_pkg.sv -----
// Shared types, command codes and constants of the LED strip frame driver.
// No dependencies; every other file of the block imports this package.
package rlsfd_pkg;

    localparam int unsigned PIX_IDX_W = 6;
    localparam int unsigned COLOR_W   = 8;
    localparam int unsigned BRI_W     = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PAT_LEN   = 8;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_SET_COLOR = 3'd1,
        CMD_SET_BRI   = 3'd2,
        CMD_SET_RAW   = 3'd3,
        CMD_PATTERN   = 3'd4,
        CMD_CANDLE    = 3'd5,
        CMD_SHOW      = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLEAR_BRI  = 3'd0,
        CFG_RED_LOW    = 3'd1,
        CFG_RED_HIGH   = 3'd2,
        CFG_GREEN_LOW  = 3'd3,
        CFG_GREEN_HIGH = 3'd4,
        CFG_BLUE_LOW   = 3'd5,
        CFG_BLUE_HIGH  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_SET_COLOR,
        OP_SET_BRI,
        OP_SET_RAW,
        OP_PATTERN,
        OP_SHIFT,
        OP_ROTATE
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PIXEL,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [BRI_W-1:0]   bri;
    } t_pixel;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op             op;
        logic [PIX_IDX_W-1:0] index;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [BRI_W-1:0]     bri;
        logic [BRI_W-1:0]     clear_bri;
    } t_cell_ctl;

    typedef struct packed {
        logic [COLOR_W-1:0] red_low;
        logic [COLOR_W-1:0] red_high;
        logic [COLOR_W-1:0] green_low;
        logic [COLOR_W-1:0] green_high;
        logic [COLOR_W-1:0] blue_low;
        logic [COLOR_W-1:0] blue_high;
    } t_clamp_cfg;

    localparam logic [BRI_W-1:0]   CLEAR_BRI_RST  = 5'd30;
    localparam logic [COLOR_W-1:0] RED_LOW_RST    = 8'd220;
    localparam logic [COLOR_W-1:0] RED_HIGH_RST   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_LOW_RST  = 8'd30;
    localparam logic [COLOR_W-1:0] GREEN_HIGH_RST = 8'd200;
    localparam logic [COLOR_W-1:0] BLUE_LOW_RST   = 8'd0;
    localparam logic [COLOR_W-1:0] BLUE_HIGH_RST  = 8'd12;

    // candle offsets as modulo-256 addends: -7, -5, -2
    localparam logic [COLOR_W-1:0] RED_BIAS   = 8'd249;
    localparam logic [COLOR_W-1:0] GREEN_BIAS = 8'd251;
    localparam logic [COLOR_W-1:0] BLUE_BIAS  = 8'd254;

    localparam logic [COLOR_W-1:0] FRAME_MARK = 8'hE0;
    localparam logic [COLOR_W-1:0] START_BYTE = 8'h00;
    localparam logic [COLOR_W-1:0] END_BYTE   = 8'hFF;

    function automatic logic [BRI_W-1:0] pattern_bri(input logic [2:0] idx);
        logic [BRI_W-1:0] v;
        case (idx)
            3'd0:    v = 5'd1;
            3'd1:    v = 5'd2;
            3'd2:    v = 5'd3;
            3'd3:    v = 5'd4;
            3'd4:    v = 5'd5;
            3'd5:    v = 5'd6;
            3'd6:    v = 5'd7;
            default: v = 5'd6;
        endcase
        return v;
    endfunction

    // with crossed limits, values above high get high and all others get low
    function automatic logic [COLOR_W-1:0] clamp8(input logic [COLOR_W-1:0] v,
                                                  input logic [COLOR_W-1:0] lo,
                                                  input logic [COLOR_W-1:0] hi);
        logic [COLOR_W-1:0] r;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rlsfd_if.sv -----
// Handshake channels of the LED strip frame driver: command, frame byte, config write.
// Depends on rlsfd_pkg for field widths.
interface rlsfd_in_if import rlsfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           cmd;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic [BRI_W-1:0]     brightness;
    logic [31:0]          raw_word;
    logic [7:0]           random_byte;

    modport source (output valid, cmd, pixel_index, red, green, blue, brightness,
                    raw_word, random_byte, input ready);
    modport sink   (input valid, cmd, pixel_index, red, green, blue, brightness,
                    raw_word, random_byte, output ready);
endinterface

interface rlsfd_out_if import rlsfd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] spi_byte;
    logic               last_byte;

    modport source (output valid, spi_byte, last_byte, input ready);
    modport sink   (input valid, spi_byte, last_byte, output ready);
endinterface

interface rlsfd_cfg_if import rlsfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rlsfd_cell.sv -----
// One pixel cell of the chain: holds red, green, blue and brightness of one LED.
// Depends on rlsfd_pkg; gets upper neighbor colour on shift, whole pixel on rotate.
module rlsfd_cell import rlsfd_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_pixel    i_next,
    output t_pixel    o_pix
);

    localparam bit HAS_PAT = (IDX < PAT_LEN);
    localparam logic [BRI_W-1:0] PAT_BRI = pattern_bri(3'(IDX % PAT_LEN));

    t_pixel r_pix;
    t_pixel n_pix;
    logic   hit;

    assign hit = (i_ctl.index == PIX_IDX_W'(IDX));

    always_comb begin
        n_pix = r_pix;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_pix.red   = '0;
                n_pix.green = '0;
                n_pix.blue  = '0;
                n_pix.bri   = i_ctl.clear_bri;
            end
            OP_SET_COLOR: begin
                if (hit) begin
                    n_pix.red   = i_ctl.red;
                    n_pix.green = i_ctl.green;
                    n_pix.blue  = i_ctl.blue;
                end
            end
            OP_SET_BRI: begin
                if (hit) begin
                    n_pix.bri = i_ctl.bri;
                end
            end
            OP_SET_RAW: begin
                if (hit) begin
                    n_pix.red   = i_ctl.red;
                    n_pix.green = i_ctl.green;
                    n_pix.blue  = i_ctl.blue;
                    n_pix.bri   = i_ctl.bri;
                end
            end
            OP_PATTERN: begin
                if (HAS_PAT) begin
                    n_pix.bri = PAT_BRI;
                end
            end
            OP_SHIFT: begin
                // colour moves down, brightness stays
                n_pix.red   = i_next.red;
                n_pix.green = i_next.green;
                n_pix.blue  = i_next.blue;
            end
            OP_ROTATE: begin
                n_pix = i_next;
            end
            default: begin
                n_pix = r_pix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ----- hw/rtl/rlsfd_candle.sv -----
// New colour of the last pixel on a candle shift: random offsets, wrap, clamp.
// Depends on rlsfd_pkg for the clamp function and bias constants.
module rlsfd_candle import rlsfd_pkg::*; (
    input  t_pixel     i_pix,
    input  logic [7:0] i_rnd,
    input  t_clamp_cfg i_lim,
    output t_pixel     o_pix
);

    logic [COLOR_W-1:0] sum_red;
    logic [COLOR_W-1:0] sum_green;
    logic [COLOR_W-1:0] sum_blue;

    // 8-bit sums wrap on their own
    assign sum_red   = i_pix.red   + {4'b0, i_rnd[7:4]} + RED_BIAS;
    assign sum_green = i_pix.green + {5'b0, i_rnd[7:5]} + GREEN_BIAS;
    assign sum_blue  = i_pix.blue  + {6'b0, i_rnd[7:6]} + BLUE_BIAS;

    assign o_pix.red   = clamp8(sum_red, i_lim.red_low, i_lim.red_high);
    assign o_pix.green = clamp8(sum_green, i_lim.green_low, i_lim.green_high);
    assign o_pix.blue  = clamp8(sum_blue, i_lim.blue_low, i_lim.blue_high);
    assign o_pix.bri   = i_pix.bri;

endmodule

// ----- hw/rtl/rgb_led_strip_frame_driver_core.sv -----
// LED strip frame driver: a chain of LED_COUNT pixel cells, a show sequencer, config regs.
// Edit commands land at the accept edge; cmd in is taken only when idle.
// Show: accept enters the head state; 4*LED_COUNT+8 bytes in all then go at one per cycle
// while the sink takes them, limited by the single output register; the chain rotates
// once per pixel so cell 0 always feeds the byte mux. Next command after the last byte loads.
// Reset (synchronous, active low) zeroes every pixel and loads the register defaults.
module rgb_led_strip_frame_driver_core import rlsfd_pkg::*; #(
    parameter int unsigned LED_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlsfd_in_if.sink   i_in,
    rlsfd_out_if.source o_out,
    rlsfd_cfg_if.sink  i_cfg
);

    localparam int unsigned PIX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(LED_COUNT - 1);

    t_state             r_state, n_state;
    logic [1:0]         r_cnt, n_cnt;
    logic [1:0]         r_sub, n_sub;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic               r_out_valid, n_out_valid;
    logic [COLOR_W-1:0] r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    logic [BRI_W-1:0]   r_clear_bri;
    t_clamp_cfg         r_lim;

    t_cell_ctl          ctl;
    t_pixel             w_pix [LED_COUNT];
    t_pixel             candle_pix;
    t_pixel             last_next;
    logic               adv;
    logic               in_acc;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_bri      <= CLEAR_BRI_RST;
            r_lim.red_low    <= RED_LOW_RST;
            r_lim.red_high   <= RED_HIGH_RST;
            r_lim.green_low  <= GREEN_LOW_RST;
            r_lim.green_high <= GREEN_HIGH_RST;
            r_lim.blue_low   <= BLUE_LOW_RST;
            r_lim.blue_high  <= BLUE_HIGH_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_CLEAR_BRI:  r_clear_bri      <= i_cfg.data[BRI_W-1:0];
                CFG_RED_LOW:    r_lim.red_low    <= i_cfg.data;
                CFG_RED_HIGH:   r_lim.red_high   <= i_cfg.data;
                CFG_GREEN_LOW:  r_lim.green_low  <= i_cfg.data;
                CFG_GREEN_HIGH: r_lim.green_high <= i_cfg.data;
                CFG_BLUE_LOW:   r_lim.blue_low   <= i_cfg.data;
                CFG_BLUE_HIGH:  r_lim.blue_high  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- cell chain ----------------
    rlsfd_candle u_candle (
        .i_pix (w_pix[LED_COUNT-1]),
        .i_rnd (i_in.random_byte),
        .i_lim (r_lim),
        .o_pix (candle_pix)
    );

    // top of the chain: wrap around on show, candle colour on shift
    assign last_next = (ctl.op == OP_ROTATE) ? w_pix[0] : candle_pix;

    for (genvar g = 0; g < LED_COUNT; g++) begin : g_cell
        if (g == LED_COUNT - 1) begin : g_top
            rlsfd_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_next  (last_next),
                .o_pix   (w_pix[g])
            );
        end else begin : g_mid
            rlsfd_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_next  (w_pix[g+1]),
                .o_pix   (w_pix[g])
            );
        end
    end

    // ---------------- sequencer ----------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && (r_state == ST_IDLE);
    assign adv        = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sub       = r_sub;
        n_pix       = r_pix;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        ctl.op        = OP_HOLD;
        ctl.index     = i_in.pixel_index;
        ctl.clear_bri = r_clear_bri;
        if (t_cmd'(i_in.cmd) == CMD_SET_RAW) begin
            ctl.red   = i_in.raw_word[31:24];
            ctl.green = i_in.raw_word[23:16];
            ctl.blue  = i_in.raw_word[15:8];
            ctl.bri   = i_in.raw_word[4:0];
        end else begin
            ctl.red   = i_in.red;
            ctl.green = i_in.green;
            ctl.blue  = i_in.blue;
            ctl.bri   = i_in.brightness;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_in.cmd))
                        CMD_CLEAR:     ctl.op = OP_CLEAR;
                        CMD_SET_COLOR: ctl.op = OP_SET_COLOR;
                        CMD_SET_BRI:   ctl.op = OP_SET_BRI;
                        CMD_SET_RAW:   ctl.op = OP_SET_RAW;
                        CMD_PATTERN:   ctl.op = OP_PATTERN;
                        CMD_CANDLE:    ctl.op = OP_SHIFT;
                        CMD_SHOW: begin
                            n_state = ST_HEAD;
                            n_cnt   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_HEAD: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = START_BYTE;
                    n_out_last  = 1'b0;
                    n_cnt       = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_state = ST_PIXEL;
                        n_sub   = '0;
                        n_pix   = '0;
                    end
                end
            end
            ST_PIXEL: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    n_sub       = r_sub + 2'd1;
                    case (r_sub)
                        2'd0:    n_out_byte = FRAME_MARK | {3'b0, w_pix[0].bri};
                        2'd1:    n_out_byte = w_pix[0].blue;
                        2'd2:    n_out_byte = w_pix[0].green;
                        default: n_out_byte = w_pix[0].red;
                    endcase
                    if (r_sub == 2'd3) begin
                        // bring the next pixel to cell 0
                        ctl.op = OP_ROTATE;
                        n_pix  = r_pix + PIX_W'(1);
                        if (r_pix == PIX_LAST) begin
                            n_state = ST_TAIL;
                            n_cnt   = '0;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = END_BYTE;
                    n_out_last  = (r_cnt == 2'd3);
                    n_cnt       = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_sub       <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sub       <= n_sub;
            r_pix       <= n_pix;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.spi_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

endmodule

// ----- hw/rtl/rlsfd_checker.sv -----
// Port-level checks of the LED strip frame driver, bound to the top level.
// Depends on rlsfd_pkg for the command codes.
module rlsfd_checker import rlsfd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic [2:0]         i_in_cmd,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [COLOR_W-1:0] i_out_byte,
    input logic               i_out_last
);

    logic in_beat;
    logic out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // stalled frame beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("frame byte changed while stalled");

    // the closing beat is an end-frame byte
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_byte == END_BYTE)
        else $error("last beat is not an end-frame byte");

    // a show keeps the command side busy
    a_show_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_cmd == CMD_SHOW) |=> !i_in_ready)
        else $error("command taken right after show");

    // only a show beat closes the command side
    a_ready_until_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && !(in_beat && (i_in_cmd == CMD_SHOW)) |=> i_in_ready)
        else $error("command side closed without a show");

endmodule

bind rgb_led_strip_frame_driver_core rlsfd_checker u_rlsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.spi_byte),
    .i_out_last  (o_out.last_byte)
);

// ----- verif/rgb_led_strip_frame_driver_core_tb.sv -----
// Self-checking testbench for rgb_led_strip_frame_driver_core: a pixel-store predictor
// checks every frame beat of show; needs rlsfd_pkg, the rlsfd_*_if interfaces and the core.
`timescale 1ns / 1ps
module rgb_led_strip_frame_driver_core_tb;
    import rlsfd_pkg::*;

    localparam int unsigned PIX_COUNT    = 8;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned PHASE_ITEMS  = 80;
    localparam int unsigned PHASES       = 5;

    localparam logic [2:0]           CMD_NONE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef struct {
        logic [2:0]           cmd;
        logic [PIX_IDX_W-1:0] index;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [BRI_W-1:0]     bri;
        logic [31:0]          raw;
        logic [7:0]           rnd;
    } t_strip_cmd;

    typedef struct {
        logic [COLOR_W-1:0] spi_byte;
        logic               last_byte;
    } t_frame_beat;

    class t_strip_scoreboard;
        t_pixel             pixels [PIX_COUNT];
        logic [BRI_W-1:0]   clear_bri;
        logic [COLOR_W-1:0] lim_lo [3];
        logic [COLOR_W-1:0] lim_hi [3];
        t_frame_beat        frame_q [$];
        int                 fails;

        function new();
            foreach (pixels[i]) pixels[i] = '0;
            clear_bri        = 5'd30;
            lim_lo[CH_RED]   = 8'd220;
            lim_hi[CH_RED]   = 8'd255;
            lim_lo[CH_GREEN] = 8'd30;
            lim_hi[CH_GREEN] = 8'd200;
            lim_lo[CH_BLUE]  = 8'd0;
            lim_hi[CH_BLUE]  = 8'd12;
            fails            = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                CFG_CLEAR_BRI:  clear_bri        = data[BRI_W-1:0];
                CFG_RED_LOW:    lim_lo[CH_RED]   = data;
                CFG_RED_HIGH:   lim_hi[CH_RED]   = data;
                CFG_GREEN_LOW:  lim_lo[CH_GREEN] = data;
                CFG_GREEN_HIGH: lim_hi[CH_GREEN] = data;
                CFG_BLUE_LOW:   lim_lo[CH_BLUE]  = data;
                CFG_BLUE_HIGH:  lim_hi[CH_BLUE]  = data;
                default: ;
            endcase
        endfunction

        // high limit is checked first; with crossed limits, values above it get it, all others get low
        function logic [COLOR_W-1:0] limit_channel(logic [COLOR_W-1:0] v,
                                                   logic [COLOR_W-1:0] lo,
                                                   logic [COLOR_W-1:0] hi);
            if (v > hi) begin
                return hi;
            end
            if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function void push_beat(logic [COLOR_W-1:0] b, logic last);
            t_frame_beat beat;
            beat.spi_byte  = b;
            beat.last_byte = last;
            frame_q.push_back(beat);
        endfunction

        function void note_input(t_strip_cmd c);
            logic               in_range;
            t_pixel             tail;
            logic [COLOR_W-1:0] nr;
            logic [COLOR_W-1:0] ng;
            logic [COLOR_W-1:0] nb;
            in_range = c.index < PIX_COUNT;
            case (c.cmd)
                CMD_CLEAR: begin
                    foreach (pixels[i]) begin
                        pixels[i]     = '0;
                        pixels[i].bri = clear_bri;
                    end
                end
                CMD_SET_COLOR: begin
                    if (in_range) begin
                        pixels[c.index].red   = c.red;
                        pixels[c.index].green = c.green;
                        pixels[c.index].blue  = c.blue;
                    end
                end
                CMD_SET_BRI: begin
                    if (in_range) begin
                        pixels[c.index].bri = c.bri;
                    end
                end
                CMD_SET_RAW: begin
                    if (in_range) begin
                        pixels[c.index].red   = c.raw[31:24];
                        pixels[c.index].green = c.raw[23:16];
                        pixels[c.index].blue  = c.raw[15:8];
                        pixels[c.index].bri   = c.raw[4:0];
                    end
                end
                CMD_PATTERN: begin
                    // ramp 1..7 then 6, only over the first eight pixels
                    for (int i = 0; i < PIX_COUNT && i < 8; i++) begin
                        pixels[i].bri = (i < 7) ? BRI_W'(i + 1) : 5'd6;
                    end
                end
                CMD_CANDLE: begin
                    tail = pixels[PIX_COUNT-1];
                    nr   = tail.red   + {4'b0, c.rnd[7:4]} - 8'd7;
                    ng   = tail.green + {5'b0, c.rnd[7:5]} - 8'd5;
                    nb   = tail.blue  + {6'b0, c.rnd[7:6]} - 8'd2;
                    for (int i = 0; i < PIX_COUNT - 1; i++) begin
                        pixels[i].red   = pixels[i+1].red;
                        pixels[i].green = pixels[i+1].green;
                        pixels[i].blue  = pixels[i+1].blue;
                    end
                    pixels[PIX_COUNT-1].red   = limit_channel(nr, lim_lo[CH_RED], lim_hi[CH_RED]);
                    pixels[PIX_COUNT-1].green = limit_channel(ng, lim_lo[CH_GREEN],
                                                              lim_hi[CH_GREEN]);
                    pixels[PIX_COUNT-1].blue  = limit_channel(nb, lim_lo[CH_BLUE],
                                                              lim_hi[CH_BLUE]);
                end
                CMD_SHOW: begin
                    repeat (4) push_beat(8'h00, 1'b0);
                    foreach (pixels[i]) begin
                        push_beat({3'b111, pixels[i].bri}, 1'b0);
                        push_beat(pixels[i].blue, 1'b0);
                        push_beat(pixels[i].green, 1'b0);
                        push_beat(pixels[i].red, 1'b0);
                    end
                    for (int i = 0; i < 4; i++) begin
                        push_beat(8'hFF, i == 3);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [COLOR_W-1:0] b, logic last);
            t_frame_beat want;
            if (frame_q.size() == 0) begin
                $error("unexpected frame beat: spi_byte 0x%02h, last_byte %0b", b, last);
                fails++;
            end else begin
                want = frame_q.pop_front();
                if (b !== want.spi_byte) begin
                    $error("spi_byte mismatch: expected 0x%02h, actual 0x%02h",
                           want.spi_byte, b);
                    fails++;
                end
                if (last !== want.last_byte) begin
                    $error("last_byte mismatch: expected %0b, actual %0b", want.last_byte, last);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    t_strip_scoreboard sb;
    int unsigned       sender_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       cycle_count;

    rlsfd_in_if  cmd_ch ();
    rlsfd_out_if beat_ch ();
    rlsfd_cfg_if reg_ch ();

    rgb_led_strip_frame_driver_core #(
        .LED_COUNT (PIX_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (beat_ch),
        .i_cfg   (reg_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // frame sink: check each accepted beat, then pick the next ready
    initial begin
        beat_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (beat_ch.valid && beat_ch.ready) begin
                    sb.check_result(beat_ch.spi_byte, beat_ch.last_byte);
                end
                beat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL rgb_led_strip_frame_driver_core");
        $finish;
    end

    task automatic send_cmd(t_strip_cmd c);
        while ($urandom_range(99) < sender_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= c.cmd;
        cmd_ch.pixel_index <= c.index;
        cmd_ch.red         <= c.red;
        cmd_ch.green       <= c.green;
        cmd_ch.blue        <= c.blue;
        cmd_ch.brightness  <= c.bri;
        cmd_ch.raw_word    <= c.raw;
        cmd_ch.random_byte <= c.rnd;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_input(c);
    endtask

    // hold the command channel until every frame beat is back, then idle a bit more
    task automatic drain(int unsigned extra);
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        do @(posedge i_clk); while (!reg_ch.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic write_limits(logic [7:0] rl, logic [7:0] rh, logic [7:0] gl,
                                logic [7:0] gh, logic [7:0] bl, logic [7:0] bh);
        write_reg(CFG_RED_LOW, rl);
        write_reg(CFG_RED_HIGH, rh);
        write_reg(CFG_GREEN_LOW, gl);
        write_reg(CFG_GREEN_HIGH, gh);
        write_reg(CFG_BLUE_LOW, bl);
        write_reg(CFG_BLUE_HIGH, bh);
    endtask

    function automatic t_strip_cmd random_fields();
        t_strip_cmd c;
        c.cmd   = 3'($urandom_range(7));
        c.index = 6'($urandom_range(63));
        c.red   = 8'($urandom_range(255));
        c.green = 8'($urandom_range(255));
        c.blue  = 8'($urandom_range(255));
        c.bri   = 5'($urandom_range(31));
        c.raw   = $urandom();
        c.rnd   = 8'($urandom_range(255));
        return c;
    endfunction

    // word carries colour in 31:8, brightness in 4:0, raw as is and random byte in 7:0
    task automatic drive_directed(logic [2:0] op, logic [PIX_IDX_W-1:0] idx, logic [31:0] word);
        t_strip_cmd c;
        c       = random_fields();
        c.cmd   = op;
        c.index = idx;
        c.red   = word[31:24];
        c.green = word[23:16];
        c.blue  = word[15:8];
        c.bri   = word[4:0];
        c.raw   = word;
        c.rnd   = word[7:0];
        send_cmd(c);
    endtask

    initial begin
        t_strip_cmd  c;
        int unsigned pick;
        logic [7:0]  lo [3];

        sb                 = new();
        sender_idle_pct    = 0;
        recv_stall_pct     = 0;
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd         <= CMD_CLEAR;
        cmd_ch.pixel_index <= '0;
        cmd_ch.red         <= '0;
        cmd_ch.green       <= '0;
        cmd_ch.blue        <= '0;
        cmd_ch.brightness  <= '0;
        cmd_ch.raw_word    <= '0;
        cmd_ch.random_byte <= '0;
        reg_ch.valid       <= 1'b0;
        reg_ch.index       <= CFG_CLEAR_BRI;
        reg_ch.data        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset frame, extremes, out-of-range pixels, pattern, candle, unused code
        drive_directed(CMD_SHOW, 6'd0, 32'h0);
        drive_directed(CMD_CLEAR, 6'd0, 32'h0);
        drive_directed(CMD_SHOW, 6'd0, 32'h0);
        drive_directed(CMD_SET_COLOR, 6'd0, 32'hFFFF_FF00);
        drive_directed(CMD_SET_COLOR, 6'd7, 32'h5AA5_0F00);
        drive_directed(CMD_SET_BRI, 6'd0, 32'h0000_001F);
        drive_directed(CMD_SET_BRI, 6'd7, 32'h0000_0000);
        drive_directed(CMD_SET_RAW, 6'd3, 32'hFFFF_FFFF);
        drive_directed(CMD_SET_RAW, 6'd4, 32'h1234_56E0);
        drive_directed(CMD_SET_COLOR, 6'd8, 32'h1111_1100);
        drive_directed(CMD_SET_RAW, 6'd63, 32'hFFFF_FFFF);
        drive_directed(CMD_SET_BRI, 6'd63, 32'h0000_001F);
        drive_directed(CMD_SHOW, 6'd0, 32'h0);
        drive_directed(CMD_PATTERN, 6'd0, 32'h0);
        drive_directed(CMD_SHOW, 6'd0, 32'h0);
        drive_directed(CMD_CANDLE, 6'd0, 32'h0000_0000);
        drive_directed(CMD_CANDLE, 6'd0, 32'h0000_00FF);
        drive_directed(CMD_CANDLE, 6'd0, 32'h0000_005A);
        drive_directed(CMD_NONE, 6'd0, 32'h0);
        drive_directed(CMD_SHOW, 6'd0, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            drain(DRAIN_CYCLES);
            case (p)
                1: begin
                    write_reg(CFG_CLEAR_BRI, 8'd0);
                    write_limits(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
                end
                2: begin
                    // upper data bits of the brightness write are dropped; limits cross
                    write_reg(CFG_CLEAR_BRI, 8'hFF);
                    write_limits(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
                    write_reg(CFG_NONE, 8'h55);
                end
                3: begin
                    write_reg(CFG_CLEAR_BRI, 8'($urandom_range(255)));
                    write_limits(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                4: begin
                    foreach (lo[i]) lo[i] = 8'($urandom_range(200));
                    write_reg(CFG_CLEAR_BRI, 8'($urandom_range(31)));
                    write_limits(lo[0], lo[0] + 8'($urandom_range(55)),
                                 lo[1], lo[1] + 8'($urandom_range(55)),
                                 lo[2], lo[2] + 8'($urandom_range(55)));
                end
                default: ;
            endcase
            reg_ch.valid <= 1'b0;
            case (p % 4)
                1: begin
                    sender_idle_pct = 79;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 79;
                end
                3: begin
                    sender_idle_pct = 31;
                    recv_stall_pct  = 31;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                c    = random_fields();
                pick = $urandom_range(99);
                if (pick < 18) begin
                    c.cmd = CMD_SHOW;
                end else if (pick < 38) begin
                    c.cmd = CMD_CANDLE;
                end else if (pick < 56) begin
                    c.cmd = CMD_SET_COLOR;
                end else if (pick < 68) begin
                    c.cmd = CMD_SET_BRI;
                end else if (pick < 82) begin
                    c.cmd = CMD_SET_RAW;
                end else if (pick < 88) begin
                    c.cmd = CMD_PATTERN;
                end else if (pick < 94) begin
                    c.cmd = CMD_CLEAR;
                end else begin
                    c.cmd = CMD_NONE;
                end
                // mostly address real pixels; the rest probe the out-of-range guard
                if ($urandom_range(4) != 0) begin
                    c.index = 6'($urandom_range(PIX_COUNT - 1));
                end
                send_cmd(c);
                if ($urandom_range(39) == 0) begin
                    drain(0);
                end
            end
        end

        drain(DRAIN_CYCLES);
        if (sb.fails == 0) begin
            $display("PASS rgb_led_strip_frame_driver_core");
        end else begin
            $display("FAIL rgb_led_strip_frame_driver_core");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rlsfd_pkg.sv
hw/rtl/rlsfd_if.sv
hw/rtl/rlsfd_cell.sv
hw/rtl/rlsfd_candle.sv
hw/rtl/rgb_led_strip_frame_driver_core.sv
hw/rtl/rlsfd_checker.sv
verif/rgb_led_strip_frame_driver_core_tb.sv
